>>> rtl/core/adf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants for the IPv4 allow/deny rule table.
// ----------------------------------------------------------------------------
package adf_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } adf_mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } adf_status_t;

    localparam logic CFG_ORDER_ALLOW_FIRST = 1'b0;
    localparam logic CFG_DEFAULT_ALLOW     = 1'b1;

    // Request travelling along the row of rule cells.
    typedef struct packed {
        logic        valid;
        adf_mode_t   mode;
        logic        kind;
        logic [31:0] addr;
        logic [31:0] mask;
        logic        hit_allow;
        logic        hit_deny;
        logic        found;
        logic        free_seen;
    } adf_token_t;

    // Update applied to the cells when a request completes.
    typedef struct packed {
        logic        add;
        logic        remove;
        logic        clear;
        logic        kind;
        logic [31:0] addr;
        logic [31:0] mask;
    } adf_commit_t;

endpackage

>>> rtl/core/adf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_cell
// One rule entry: compares the passing request and forwards it to the next cell.
// ----------------------------------------------------------------------------
module adf_cell
    import adf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  adf_token_t  tok_in,
    input  adf_commit_t commit,
    output adf_token_t  tok_out
);

    logic        valid_reg;
    logic        allow_reg;
    logic [31:0] addr_reg;
    logic [31:0] mask_reg;
    logic        sel_reg;
    adf_token_t  tok_reg;
    adf_token_t  tok_next;
    logic        sel_next;
    logic        masked_match;
    logic        exact;

    always_comb begin
        masked_match = valid_reg && ((tok_in.addr & mask_reg) == (addr_reg & mask_reg));
        exact = valid_reg && (allow_reg == tok_in.kind) && (addr_reg == tok_in.addr)
                && (mask_reg == tok_in.mask);
        tok_next = tok_in;
        if (tok_in.mode == MODE_LOOKUP) begin
            tok_next.hit_allow = tok_in.hit_allow | (masked_match & allow_reg);
            tok_next.hit_deny  = tok_in.hit_deny  | (masked_match & ~allow_reg);
        end
        tok_next.found     = tok_in.found | exact;
        tok_next.free_seen = tok_in.free_seen | ~valid_reg;
        if (tok_in.mode == MODE_ADD) begin
            sel_next = ~valid_reg & ~tok_in.free_seen;
        end else begin
            sel_next = exact;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                sel_reg <= sel_next;
            end
            if (commit.clear) begin
                valid_reg <= 1'b0;
            end else if (commit.add && sel_reg) begin
                valid_reg <= 1'b1;
            end else if (commit.remove && sel_reg) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit.add && sel_reg && !commit.clear) begin
            allow_reg <= commit.kind;
            addr_reg  <= commit.addr;
            mask_reg  <= commit.mask;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/ip_allow_deny_filter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_allow_deny_filter_table
// IPv4 allow/deny rule table built as a row of rule cells.
// ----------------------------------------------------------------------------
// Flow: a new request is accepted only once the previous one commits; each
// request walks the row of rule cells one cell per cycle, then the update is
// applied at commit, which waits while a held result is not yet taken.
// Reset: synchronous, active low; clears all rules, the count and both
// configuration registers.
module ip_allow_deny_filter_table
    import adf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_rule_is_allow,
    input  logic [31:0] s_ip_address,
    input  logic [31:0] s_net_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_allowed,
    output logic [4:0]  m_rule_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    adf_token_t     tok [0:TABLE_ENTRIES];
    adf_token_t     tok0_reg;
    adf_token_t     tok0_next;
    adf_token_t     pend_reg;
    logic           pend_valid_reg;
    adf_token_t     src;
    adf_commit_t    commit_bus;
    logic           busy_reg;
    logic           have;
    logic           commit;
    logic           accept;
    logic           order_allow_first_reg;
    logic           default_allow_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    adf_status_t    status_next;
    logic           allowed_next;
    logic           m_valid_reg;
    logic [1:0]     m_status_reg;
    logic           m_allowed_reg;
    logic [4:0]     m_rule_count_reg;
    logic [31:0]    count_ext;

    assign tok[0] = tok0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            adf_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok[gi]),
                .commit  (commit_bus),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        src    = pend_valid_reg ? pend_reg : tok[TABLE_ENTRIES];
        have   = pend_valid_reg || tok[TABLE_ENTRIES].valid;
        commit = have && (!m_valid_reg || m_ready);
        accept = s_valid && s_ready;

        tok0_next = '0;
        if (accept) begin
            tok0_next.valid = 1'b1;
            tok0_next.mode  = adf_mode_t'(s_mode);
            tok0_next.kind  = s_rule_is_allow;
            tok0_next.addr  = s_ip_address;
            tok0_next.mask  = s_net_mask;
        end

        commit_bus        = '0;
        commit_bus.kind   = src.kind;
        commit_bus.addr   = src.addr;
        commit_bus.mask   = src.mask;
        count_next        = count_reg;
        status_next       = ST_OK;
        allowed_next      = 1'b0;

        case (src.mode)
            MODE_LOOKUP: begin
                if (order_allow_first_reg) begin
                    allowed_next = src.hit_allow ? 1'b1 :
                                   (src.hit_deny ? 1'b0 : default_allow_reg);
                end else begin
                    allowed_next = src.hit_deny ? 1'b0 :
                                   (src.hit_allow ? 1'b1 : default_allow_reg);
                end
            end
            MODE_ADD: begin
                if (!src.found) begin
                    if (src.free_seen) begin
                        commit_bus.add = commit;
                        count_next     = count_reg + CNT_W'(1);
                    end else begin
                        status_next = ST_FULL;
                    end
                end
            end
            MODE_REMOVE: begin
                if (src.found) begin
                    commit_bus.remove = commit;
                    count_next        = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            MODE_CLEAR: begin
                commit_bus.clear = commit;
                count_next       = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase

        count_ext = 32'(count_next);
    end

    assign s_ready   = !busy_reg || commit;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg              <= 1'b0;
            tok0_reg              <= '0;
            pend_valid_reg        <= 1'b0;
            pend_reg              <= '0;
            count_reg             <= '0;
            order_allow_first_reg <= 1'b0;
            default_allow_reg     <= 1'b0;
            m_valid_reg           <= 1'b0;
            m_status_reg          <= ST_OK;
            m_allowed_reg         <= 1'b0;
            m_rule_count_reg      <= '0;
        end else begin
            tok0_reg <= tok0_next;
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end

            if (commit) begin
                pend_valid_reg <= 1'b0;
            end else if (tok[TABLE_ENTRIES].valid) begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= tok[TABLE_ENTRIES];
            end

            if (commit) begin
                count_reg        <= count_next;
                m_valid_reg      <= 1'b1;
                m_status_reg     <= status_next;
                m_allowed_reg    <= allowed_next;
                m_rule_count_reg <= count_ext[4:0];
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ORDER_ALLOW_FIRST: order_allow_first_reg <= cfg_data;
                    CFG_DEFAULT_ALLOW:     default_allow_reg     <= cfg_data;
                    default: begin
                        default_allow_reg <= default_allow_reg;
                    end
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_allowed    = m_allowed_reg;
    assign m_rule_count = m_rule_count_reg;

endmodule
